// File: sv/emr_pkg.sv
// ----------------------------------------------------------------------------
// emr_pkg
// shared types, constants and helpers of the eller maze row generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package emr_pkg;

  localparam int LBL_W     = 6;   // set label width, 0 means no set
  localparam int RR_W      = 31;  // right wall field width
  localparam int BW_W      = 32;  // bottom wall field width
  localparam int CELLS_MAX = 32;  // widest row the fields can carry
  localparam int MW_W      = 6;   // maze_width register width
  localparam logic [MW_W-1:0] MW_RESET = 6'd32;
  localparam int NUM_LBL   = 1 << LBL_W;

  typedef logic [LBL_W-1:0] label_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_USED, ST_FILL, ST_MERGE, ST_CLOSE,
    ST_BOTTOM, ST_HOLES, ST_FINISH, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_USED, OP_FILL, OP_MERGE, OP_CLOSE, OP_BOTTOM, OP_HOLES, OP_FINISH
  } op_t;

  typedef struct packed {
    logic load;   // capture item, reset pass state
    op_t  op;     // datapath operation this cycle
    logic emit;   // load result register
  } cmd_t;

  typedef struct packed {
    logic idx_last;  // walking index is at the last cell in use
    logic last_row;  // current item closes the maze
    logic out_busy;  // result register holds an untaken item
  } status_t;

  // smallest nonzero label not marked in use
  function automatic label_t free_label(input logic [NUM_LBL-1:0] used);
    label_t res;
    res = label_t'(1);
    for (int c = NUM_LBL - 1; c >= 1; c--) begin
      if (!used[c]) res = label_t'(c);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: sv/emr_if.sv
// ----------------------------------------------------------------------------
// emr channel interfaces
// valid/ready channels for row items, results and the width register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface emr_in_if;
  import emr_pkg::*;
  logic            valid;
  logic            ready;
  logic [RR_W-1:0] right_random;
  logic [BW_W-1:0] bottom_random;
  logic            first_row;
  logic            last_row;
  modport source (output valid, right_random, bottom_random, first_row, last_row,
                  input ready);
  modport sink   (input valid, right_random, bottom_random, first_row, last_row,
                  output ready);
endinterface

interface emr_out_if;
  import emr_pkg::*;
  logic            valid;
  logic            ready;
  logic [RR_W-1:0] right_walls;
  logic [BW_W-1:0] bottom_walls;
  logic            final_row;
  modport source (output valid, right_walls, bottom_walls, final_row, input ready);
  modport sink   (input valid, right_walls, bottom_walls, final_row, output ready);
endinterface

interface emr_cfg_if;
  import emr_pkg::*;
  logic            valid;
  logic            ready;
  logic [MW_W-1:0] maze_width;
  modport source (output valid, maze_width, input ready);
  modport sink   (input valid, maze_width, output ready);
endinterface

`default_nettype wire

// File: sv/emr_ctrl.sv
// ----------------------------------------------------------------------------
// emr_ctrl
// pass sequencer of the maze row generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module emr_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  output emr_pkg::cmd_t    cmd,
  input  emr_pkg::status_t status
);
  import emr_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '{load: 1'b0, op: OP_NONE, emit: 1'b0};
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_USED;
        end
      end
      ST_USED: begin
        cmd.op = OP_USED;
        if (status.idx_last) state_next = ST_FILL;
      end
      ST_FILL: begin
        cmd.op = OP_FILL;
        if (status.idx_last) state_next = ST_MERGE;
      end
      ST_MERGE: begin
        cmd.op = OP_MERGE;
        if (status.idx_last) state_next = status.last_row ? ST_CLOSE : ST_BOTTOM;
      end
      ST_CLOSE: begin
        cmd.op = OP_CLOSE;
        if (status.idx_last) state_next = ST_FINISH;
      end
      ST_BOTTOM: begin
        cmd.op = OP_BOTTOM;
        if (status.idx_last) state_next = ST_HOLES;
      end
      ST_HOLES: begin
        cmd.op = OP_HOLES;
        if (status.idx_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.op     = OP_FINISH;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !status.out_busy) else $error("result emitted over a waiting one");
  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_USED) else $error("item load did not start a pass");
  a_fill_to_merge: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL && status.idx_last) |=> state == ST_MERGE)
    else $error("fill pass did not hand over to merge pass");

endmodule

`default_nettype wire

// File: sv/emr_datapath.sv
// ----------------------------------------------------------------------------
// emr_datapath
// label row, wall registers and result register of the maze row generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module emr_datapath #(
  parameter int MAX_WIDTH = 32
) (
  input  wire                       clk,
  input  wire                       rst,
  input  emr_pkg::cmd_t             cmd,
  output emr_pkg::status_t          status,
  input  wire                       cfg_valid,
  input  wire [emr_pkg::MW_W-1:0]   cfg_width,
  input  wire [emr_pkg::RR_W-1:0]   in_right,
  input  wire [emr_pkg::BW_W-1:0]   in_bottom,
  input  wire                       in_first,
  input  wire                       in_last,
  output logic                      out_valid,
  input  wire                       out_ready,
  output logic [emr_pkg::RR_W-1:0]  out_right,
  output logic [emr_pkg::BW_W-1:0]  out_bottom,
  output logic                      out_final
);
  import emr_pkg::*;

  localparam int IW   = $clog2(MAX_WIDTH);
  localparam int WCAP = (MAX_WIDTH < CELLS_MAX) ? MAX_WIDTH : CELLS_MAX;

  logic [MW_W-1:0]    maze_width;
  logic [MW_W-1:0]    w_eff;
  logic [MW_W-1:0]    row_w;
  label_t             label [MAX_WIDTH];
  logic [NUM_LBL-1:0] used;
  logic [IW-1:0]      idx;
  label_t             prev;
  logic [RR_W-1:0]    rr, rw;
  logic [BW_W-1:0]    rb, bw;
  logic               last_row;
  logic [MAX_WIDTH-1:0] lane_on;
  label_t             cur, free_lbl;
  logic [4:0]         pos, pos_m1;
  logic               others, hole, walking;

  always_comb begin
    if (maze_width == '0)                w_eff = MW_W'(1);
    else if (maze_width > MW_W'(WCAP))   w_eff = MW_W'(WCAP);
    else                                 w_eff = maze_width;
  end

  always_comb begin
    for (int l = 0; l < MAX_WIDTH; l++) lane_on[l] = (7'(l) < 7'(row_w));
  end

  assign cur      = label[idx];
  assign free_lbl = free_label(used);
  assign pos      = 5'(idx);
  assign pos_m1   = pos - 5'd1;
  assign walking  = (cmd.op != OP_NONE) && (cmd.op != OP_FINISH);

  always_comb begin
    others = 1'b0;
    hole   = 1'b0;
    for (int l = 0; l < MAX_WIDTH; l++) begin
      if (lane_on[l] && label[l] == cur) begin
        if (IW'(l) != idx) others = 1'b1;
        if (!bw[5'(l)])    hole   = 1'b1;
      end
    end
  end

  assign status.idx_last = (7'(idx) == 7'(row_w) - 7'd1);
  assign status.last_row = last_row;
  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      maze_width <= MW_RESET;
      idx        <= '0;
      out_valid  <= 1'b0;
      for (int l = 0; l < MAX_WIDTH; l++) label[l] <= '0;
    end else begin
      if (cfg_valid) maze_width <= cfg_width;
      if (out_valid && out_ready) out_valid <= 1'b0;

      if (walking) idx <= status.idx_last ? '0 : idx + IW'(1);

      if (cmd.load) begin
        row_w    <= w_eff;
        rr       <= in_right;
        rb       <= in_bottom;
        last_row <= in_last;
        used     <= '0;
        rw       <= '0;
        bw       <= '0;
        idx      <= '0;
        if (in_first) for (int l = 0; l < MAX_WIDTH; l++) label[l] <= '0;
      end

      unique case (cmd.op)
        OP_NONE: ;
        OP_USED: used[cur] <= 1'b1;
        OP_FILL: begin
          if (cur == '0) begin
            label[idx]     <= free_lbl;
            used[free_lbl] <= 1'b1;
          end
        end
        OP_MERGE: begin
          if (idx == '0) prev <= cur;
          else if (rr[pos_m1] || prev == cur) begin
            rw[pos_m1] <= 1'b1;
            prev       <= cur;
          end else begin
            for (int l = 0; l < MAX_WIDTH; l++)
              if (lane_on[l] && label[l] == cur) label[l] <= prev;
          end
        end
        OP_CLOSE: begin
          if (idx == '0 || prev == cur) prev <= cur;
          else begin
            rw[pos_m1] <= 1'b0;
            for (int l = 0; l < MAX_WIDTH; l++)
              if (lane_on[l] && label[l] == cur) label[l] <= prev;
          end
        end
        OP_BOTTOM: bw[pos] <= rb[pos] && others;
        OP_HOLES:  if (!hole) bw[pos] <= 1'b0;
        OP_FINISH: begin
          for (int l = 0; l < MAX_WIDTH; l++) begin
            if (lane_on[l] && (last_row || bw[5'(l)])) label[l] <= '0;
          end
          if (last_row) begin
            for (int l = 0; l < BW_W; l++) bw[l] <= (7'(l) < 7'(row_w));
          end
        end
        default: ;
      endcase

      if (cmd.emit) begin
        out_valid  <= 1'b1;
        out_right  <= rw;
        out_bottom <= bw;
        out_final  <= last_row;
      end
    end
  end

  a_free_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_FILL |-> free_lbl != '0) else $error("fresh label is no set");
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid) else $error("emitted result not marked valid");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_right) && $stable(out_bottom)
                                   && $stable(out_final)))
    else $error("waiting result changed");

endmodule

`default_nettype wire

// File: sv/eller_maze_row_generator_unit.sv
// ----------------------------------------------------------------------------
// eller_maze_row_generator_unit
// eller maze row generator: one row of walls per item, labels kept per column
// ----------------------------------------------------------------------------
// passes after accept: used-label sweep, fresh labels, merges, then bottom walls
//   and hole repair, or the closing merge on the closing row, finish, result load
// a new item is taken only once the last result is loaded, which waits while an
//   earlier result is untaken; each pass walks the label read port once per cell
// reset: labels cleared, maze_width back to 32, no result pending
`timescale 1ns / 1ps
`default_nettype none

module eller_maze_row_generator_unit #(
  parameter int MAX_WIDTH = 32
) (
  input wire clk,
  input wire rst,
  emr_in_if.sink    in_ch,
  emr_out_if.source out_ch,
  emr_cfg_if.sink   cfg_ch
);
  import emr_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  // width register always takes a write; user must write it only while idle, unchecked
  assign cfg_ch.ready = 1'b1;
  // new row is taken only in idle, the result register parts the output side
  assign in_ch.ready  = in_ready;

  // sequencer: used-label sweep, fresh labels, merges, then bottom walls and
  // hole repair, or the closing merge on the last row
  emr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  // label row with per-lane relabel compare, wall registers, result register
  emr_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_valid  (cfg_ch.valid),
    .cfg_width  (cfg_ch.maze_width),
    .in_right   (in_ch.right_random),
    .in_bottom  (in_ch.bottom_random),
    .in_first   (in_ch.first_row),
    .in_last    (in_ch.last_row),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_right  (out_ch.right_walls),
    .out_bottom (out_ch.bottom_walls),
    .out_final  (out_ch.final_row)
  );

endmodule

`default_nettype wire
